// ===== rtl/trmd_pkg.sv =====
package trmd_pkg;

  localparam int RAY_W       = 16;
  localparam int BASE_W      = 16;
  localparam int DEPTH_W     = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam int RAY_FRAC    = 12;
  localparam int TRANS_FRAC  = 8;
  localparam int DEPTH_FRAC  = 16;
  localparam int DEPTH_SHIFT = DEPTH_FRAC + 4 * RAY_FRAC - (4 * RAY_FRAC + TRANS_FRAC) - 1;

  localparam int PROD_W = 2 * RAY_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int WIDE_W = 2 * DOT_W;
  localparam int DET_W  = 64;
  localparam int LO_W   = DOT_W;
  localparam int HI_W   = WIDE_W - LO_W;
  localparam int PH_W   = RAY_W + HI_W;
  localparam int PL_W   = RAY_W + LO_W + 1;
  localparam int NUM_W  = 82;
  localparam int MAG_W  = NUM_W - 1;
  localparam int REM_W  = MAG_W + DEPTH_SHIFT + 2;
  localparam int DEN_W  = DET_W + 1;
  localparam int QUO_W  = DEPTH_W;
  localparam int CMP_W  = DEN_W + QUO_W;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SINGULAR  = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASELINE_X = 4'd0,
    REG_BASELINE_Y = 4'd1,
    REG_BASELINE_Z = 4'd2
  } reg_index_t;

endpackage

// ===== rtl/two_ray_midpoint_depth_top.sv =====
// Channel  Dir  Handshake             Payload
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data (baseline x, y, z)
// in       in   in_valid/in_ready     first_ray_x/y/z, second_ray_x/y/z
// out      out  out_valid/out_ready   depth_value, status_code
// One request per cycle while in_ready is high.
// Pipeline: 9 arithmetic stages, 32 restoring divide stages (one quotient bit each), 1 result
// stage and the output register.
// Reset clears the baseline registers and all valid bits; cfg_ready is always high.
// An output register plus one spare entry absorb a stall; in_ready drops only while the
// spare entry is full, and then every stage holds.
module two_ray_midpoint_depth_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [trmd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [trmd_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [trmd_pkg::RAY_W-1:0]      first_ray_x,
  input  logic signed [trmd_pkg::RAY_W-1:0]      first_ray_y,
  input  logic signed [trmd_pkg::RAY_W-1:0]      first_ray_z,
  input  logic signed [trmd_pkg::RAY_W-1:0]      second_ray_x,
  input  logic signed [trmd_pkg::RAY_W-1:0]      second_ray_y,
  input  logic signed [trmd_pkg::RAY_W-1:0]      second_ray_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [trmd_pkg::DEPTH_W-1:0]    depth_value,
  output logic [1:0]                             status_code
);
  import trmd_pkg::*;

  localparam int NSTAGE = 9 + QUO_W + 1;

  typedef struct packed {
    logic               sing;
    logic               neg;
    logic               ovf;
    logic [REM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [QUO_W-1:0]   quo;
  } div_t;

  logic signed [BASE_W-1:0] base_x, base_y, base_z;
  logic                     en, in_fire, arr, take;
  logic [NSTAGE-1:0]        stage_valid;

  logic signed [RAY_W-1:0]  p [3];
  logic signed [RAY_W-1:0]  q [3];
  logic signed [BASE_W-1:0] t [3];

  logic signed [PROD_W-1:0] s1_pp [3];
  logic signed [PROD_W-1:0] s1_qq [3];
  logic signed [PROD_W-1:0] s1_pq [3];
  logic signed [PROD_W-1:0] s1_tp [3];
  logic signed [PROD_W-1:0] s1_tq [3];
  logic signed [RAY_W-1:0]  s1_p2, s1_q2;

  logic signed [DOT_W-1:0]  s2_a11, s2_a22, s2_c, s2_tv1, s2_tv2;
  logic signed [RAY_W-1:0]  s2_p2, s2_q2;

  logic signed [WIDE_W-1:0] s3_aa, s3_cc, s3_at1, s3_ct2, s3_ct1, s3_at2;
  logic signed [RAY_W-1:0]  s3_p2, s3_q2;

  logic [DET_W-1:0]         s4_det;
  logic signed [WIDE_W-1:0] s4_lam, s4_alp;
  logic signed [RAY_W-1:0]  s4_p2, s4_q2;

  logic                     s5_sing;
  logic [DET_W-1:0]         s5_det;
  logic signed [PH_W-1:0]   s5_ph1, s5_ph2;
  logic signed [PL_W-1:0]   s5_pl1, s5_pl2;

  logic                     s6_sing;
  logic [DET_W-1:0]         s6_det;
  logic signed [NUM_W-1:0]  s6_num;

  logic                     s7_sing, s7_neg;
  logic [DET_W-1:0]         s7_det;
  logic [MAG_W-1:0]         s7_mag;

  logic                     s8_sing, s8_neg;
  logic [REM_W-1:0]         s8_rem;
  logic [DEN_W-1:0]         s8_den;

  div_t                     dst      [QUO_W+1];
  div_t                     dst_next [QUO_W];

  logic [DEPTH_W-1:0]       fin_depth, fdepth;
  status_t                  fin_status, fstatus;

  logic                     rv, sv;
  logic [DEPTH_W-1:0]       rdepth, sdepth;
  status_t                  rstatus, sstatus;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x <= '0;
      base_y <= '0;
      base_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASELINE_X: base_x <= $signed(cfg_data);
        REG_BASELINE_Y: base_y <= $signed(cfg_data);
        REG_BASELINE_Z: base_z <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign en       = !sv;
  assign in_ready = en;
  assign in_fire  = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (en) begin
      stage_valid <= {stage_valid[NSTAGE-2:0], in_fire};
    end
  end

  assign p[0] = first_ray_x;
  assign p[1] = first_ray_y;
  assign p[2] = first_ray_z;
  assign q[0] = second_ray_x;
  assign q[1] = second_ray_y;
  assign q[2] = second_ray_z;
  assign t[0] = base_x;
  assign t[1] = base_y;
  assign t[2] = base_z;

  // element products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s1_pp[j] <= PROD_W'(p[j]) * PROD_W'(p[j]);
        s1_qq[j] <= PROD_W'(q[j]) * PROD_W'(q[j]);
        s1_pq[j] <= PROD_W'(p[j]) * PROD_W'(q[j]);
        s1_tp[j] <= PROD_W'(t[j]) * PROD_W'(p[j]);
        s1_tq[j] <= PROD_W'(t[j]) * PROD_W'(q[j]);
      end
      s1_p2 <= first_ray_z;
      s1_q2 <= second_ray_z;
    end
  end

  // dot products
  always_ff @(posedge clk) begin
    if (en) begin
      s2_a11 <= DOT_W'(s1_pp[0]) + DOT_W'(s1_pp[1]) + DOT_W'(s1_pp[2]);
      s2_a22 <= DOT_W'(s1_qq[0]) + DOT_W'(s1_qq[1]) + DOT_W'(s1_qq[2]);
      s2_c   <= DOT_W'(s1_pq[0]) + DOT_W'(s1_pq[1]) + DOT_W'(s1_pq[2]);
      s2_tv1 <= DOT_W'(s1_tp[0]) + DOT_W'(s1_tp[1]) + DOT_W'(s1_tp[2]);
      s2_tv2 <= DOT_W'(s1_tq[0]) + DOT_W'(s1_tq[1]) + DOT_W'(s1_tq[2]);
      s2_p2  <= s1_p2;
      s2_q2  <= s1_q2;
    end
  end

  // system products
  always_ff @(posedge clk) begin
    if (en) begin
      s3_aa  <= WIDE_W'(s2_a11) * WIDE_W'(s2_a22);
      s3_cc  <= WIDE_W'(s2_c) * WIDE_W'(s2_c);
      s3_at1 <= WIDE_W'(s2_a22) * WIDE_W'(s2_tv1);
      s3_ct2 <= WIDE_W'(s2_c) * WIDE_W'(s2_tv2);
      s3_ct1 <= WIDE_W'(s2_c) * WIDE_W'(s2_tv1);
      s3_at2 <= WIDE_W'(s2_a11) * WIDE_W'(s2_tv2);
      s3_p2  <= s2_p2;
      s3_q2  <= s2_q2;
    end
  end

  // determinant and unscaled factors
  always_ff @(posedge clk) begin
    if (en) begin
      s4_det <= DET_W'(s3_aa - s3_cc);
      s4_lam <= s3_ct2 - s3_at1;
      s4_alp <= s3_at2 - s3_ct1;
      s4_p2  <= s3_p2;
      s4_q2  <= s3_q2;
    end
  end

  // split the z products into high and low partial products
  always_ff @(posedge clk) begin
    if (en) begin
      s5_sing <= (s4_det == '0);
      s5_det  <= s4_det;
      s5_ph1  <= PH_W'(s4_p2) * PH_W'($signed(s4_lam[WIDE_W-1:LO_W]));
      s5_ph2  <= PH_W'(s4_q2) * PH_W'($signed(s4_alp[WIDE_W-1:LO_W]));
      s5_pl1  <= PL_W'(s4_p2) * PL_W'($signed({1'b0, s4_lam[LO_W-1:0]}));
      s5_pl2  <= PL_W'(s4_q2) * PL_W'($signed({1'b0, s4_alp[LO_W-1:0]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sing <= s5_sing;
      s6_det  <= s5_det;
      s6_num  <= ((NUM_W'(s5_ph1) + NUM_W'(s5_ph2)) <<< LO_W)
                 + NUM_W'(s5_pl1) + NUM_W'(s5_pl2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sing <= s6_sing;
      s7_det  <= s6_det;
      s7_neg  <= s6_num[NUM_W-1];
      s7_mag  <= s6_num[NUM_W-1] ? MAG_W'(-s6_num) : MAG_W'(s6_num);
    end
  end

  // rounded dividend 2*(mag << DEPTH_SHIFT) + det against divisor 2*det
  always_ff @(posedge clk) begin
    if (en) begin
      s8_sing <= s7_sing;
      s8_neg  <= s7_neg;
      s8_rem  <= (REM_W'(s7_mag) << (DEPTH_SHIFT + 1)) + REM_W'(s7_det);
      s8_den  <= {s7_det, 1'b0};
    end
  end

  generate
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int B = QUO_W - 1 - k;
      logic [CMP_W:0] diff;
      assign diff = {1'b0, CMP_W'(dst[k].rem)} - {1'b0, CMP_W'(dst[k].den) << B};
      always_comb begin
        dst_next[k] = dst[k];
        if (!diff[CMP_W]) begin
          dst_next[k].rem    = diff[REM_W-1:0];
          dst_next[k].quo[B] = 1'b1;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      dst[0].sing <= s8_sing;
      dst[0].neg  <= s8_neg;
      dst[0].ovf  <= CMP_W'(s8_rem) >= (CMP_W'(s8_den) << QUO_W);
      dst[0].rem  <= s8_rem;
      dst[0].den  <= s8_den;
      dst[0].quo  <= '0;
      for (int j = 0; j < QUO_W; j++) begin
        dst[j+1] <= dst_next[j];
      end
    end
  end

  always_comb begin
    fin_depth  = dst[QUO_W].quo;
    fin_status = STATUS_OK;
    if (dst[QUO_W].sing) begin
      fin_depth  = '0;
      fin_status = STATUS_SINGULAR;
    end else if (dst[QUO_W].neg) begin
      if (dst[QUO_W].ovf || (dst[QUO_W].quo[QUO_W-1] && |dst[QUO_W].quo[QUO_W-2:0])) begin
        fin_depth  = DEPTH_MIN;
        fin_status = STATUS_SATURATED;
      end else begin
        fin_depth  = -dst[QUO_W].quo;
      end
    end else if (dst[QUO_W].ovf || dst[QUO_W].quo[QUO_W-1]) begin
      fin_depth  = DEPTH_MAX;
      fin_status = STATUS_SATURATED;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fdepth  <= fin_depth;
      fstatus <= fin_status;
    end
  end

  assign take = !rv || out_ready;
  assign arr  = en && stage_valid[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
      sv <= 1'b0;
    end else if (take) begin
      if (sv) begin
        rv      <= 1'b1;
        rdepth  <= sdepth;
        rstatus <= sstatus;
        sv      <= 1'b0;
      end else begin
        rv <= arr;
        if (arr) begin
          rdepth  <= fdepth;
          rstatus <= fstatus;
        end
      end
    end else if (arr) begin
      sv      <= 1'b1;
      sdepth  <= fdepth;
      sstatus <= fstatus;
    end
  end

  assign out_valid   = rv;
  assign depth_value = $signed(rdepth);
  assign status_code = rstatus;

endmodule

// ===== rtl/trmd_checker.sv =====
module trmd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [trmd_pkg::DEPTH_W-1:0] depth_value,
  input logic [1:0]                          status_code
);
  import trmd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(depth_value) && $stable(status_code))
    else $error("output request dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_code == STATUS_SINGULAR |-> depth_value == '0)
    else $error("singular result with nonzero depth");

  a_saturated_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_code == STATUS_SATURATED |->
      depth_value == $signed(DEPTH_MAX) || depth_value == $signed(DEPTH_MIN))
    else $error("saturated result not at a limit");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without an output stall");

endmodule

bind two_ray_midpoint_depth_top trmd_checker u_trmd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .depth_value (depth_value),
  .status_code (status_code)
);
